FILE: rtl/pwsel_pkg.sv
package pwsel_pkg;

    localparam int SUM_W = 29;   // diff sum, sized for rows of up to 4096 elements
    localparam int SQ_W  = 44;   // sum of squared differences
    localparam int N_W   = 13;   // element count of a row
    localparam int DIV_W = 72;   // divider dividend and quotient
    localparam int DEN_W = 64;   // divider divisor
    localparam int E_W   = 36;   // per-row loss E before weighting
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] MODE_ROW  = 2'd0;
    localparam logic [1:0] MODE_SUM  = 2'd1;
    localparam logic [1:0] MODE_MEAN = 2'd2;
    localparam logic [1:0] MODE_NZ   = 2'd3;

    localparam logic ADDR_MODE = 1'b0;
    localparam logic ADDR_FC   = 1'b1;

    localparam logic signed [63:0] ACC_LIM = 64'sd1 <<< 62;
    localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< 47) - 64'sd1;
    localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< 47);

    typedef struct packed {
        logic signed [15:0] prediction;
        logic signed [15:0] label;
        logic signed [15:0] row_weight;
        logic               batch_end;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] loss;
        logic               is_total;
    } t_out_item;

    // one finished row handed from front to back
    typedef struct packed {
        logic signed [SUM_W-1:0] diff_sum;
        logic [SQ_W-1:0]         sq_sum;
        logic [N_W-1:0]          n;
        logic signed [15:0]      weight;
        logic                    batch_end;
    } t_row;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DEN_W-1:0]  divisor;
    } t_div_req;

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = v;
        if (v > OUT_MAX) c = OUT_MAX;
        if (v < OUT_MIN) c = OUT_MIN;
        return c[47:0];
    endfunction

endpackage

FILE: rtl/pwsel_queue.sv
module pwsel_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pwsel_pkg::t_row   i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output pwsel_pkg::t_row   o_data
);
    localparam int D  = pwsel_pkg::QUEUE_DEPTH;
    localparam int AW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);

    pwsel_pkg::t_row r_mem [D];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(D));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(D - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(D - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end
endmodule

FILE: rtl/pwsel_front.sv
module pwsel_front #(
    parameter int FEATURES_MAX = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [8:0]          i_feature_count,
    input  logic                i_valid,
    output logic                o_ready,
    input  pwsel_pkg::t_in_item i_item,
    input  logic                i_q_full,
    output logic                o_push,
    output pwsel_pkg::t_row     o_row
);
    localparam int NW = pwsel_pkg::N_W;
    localparam int SW = pwsel_pkg::SUM_W;
    localparam int QW = pwsel_pkg::SQ_W;
    localparam int IW = $clog2(FEATURES_MAX);

    logic signed [SW-1:0] r_sum, n_sum;
    logic [QW-1:0]        r_sq, n_sq;
    logic [IW-1:0]        r_idx;
    logic signed [16:0]   d;
    logic [15:0]          mag;
    logic [NW-1:0]        fc, n_eff, taken;
    logic                 accept, row_end;

    assign fc = NW'(i_feature_count);
    always_comb begin
        n_eff = fc;
        if (fc < NW'(2)) n_eff = NW'(2);
        if (fc > NW'(FEATURES_MAX)) n_eff = NW'(FEATURES_MAX);
    end

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    assign d     = 17'(i_item.prediction) - 17'(i_item.label);
    assign mag   = d[16] ? 16'(-d) : d[15:0];
    assign n_sum = r_sum + SW'(d);
    assign n_sq  = r_sq + QW'({16'd0, mag} * {16'd0, mag});
    assign taken = NW'(r_idx) + 1'b1;
    assign row_end = (taken >= n_eff);

    assign o_push = accept && row_end;
    assign o_row  = '{diff_sum: n_sum, sq_sum: n_sq, n: n_eff,
                      weight: i_item.row_weight, batch_end: i_item.batch_end};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_sq  <= '0;
            r_idx <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_sum <= '0;
                r_sq  <= '0;
                r_idx <= '0;
            end else begin
                r_sum <= n_sum;
                r_sq  <= n_sq;
                r_idx <= r_idx + 1'b1;
            end
        end
    end
endmodule

FILE: rtl/pwsel_div.sv
module pwsel_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pwsel_pkg::t_div_req           i_req,
    output logic                          o_done,
    output logic [pwsel_pkg::DIV_W-1:0]   o_quotient
);
    localparam int DW = pwsel_pkg::DIV_W;
    localparam int BW = pwsel_pkg::DEN_W;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q;
    logic [BW-1:0] r_rem, r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [BW:0]   sh;
    logic          ge;

    // restoring division, one quotient bit a cycle
    assign sh = {r_rem, r_q[DW-1]};
    assign ge = (sh >= {1'b0, r_den});

    assign o_done     = r_done;
    assign o_quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_q    <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? BW'(sh - {1'b0, r_den}) : sh[BW-1:0];
                r_q   <= {r_q[DW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: rtl/pwsel_back.sv
module pwsel_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_mode,
    input  logic                 i_q_valid,
    input  pwsel_pkg::t_row      i_row,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pwsel_pkg::t_out_item o_item
);
    localparam int SW = pwsel_pkg::SUM_W;
    localparam int QW = pwsel_pkg::SQ_W;
    localparam int NW = pwsel_pkg::N_W;
    localparam int DW = pwsel_pkg::DIV_W;
    localparam int BW = pwsel_pkg::DEN_W;
    localparam int EW = pwsel_pkg::E_W;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_DIFF  = 8'b0000_0100,
        ST_DIV_E = 8'b0000_1000,
        ST_WMUL  = 8'b0001_0000,
        ST_ACC   = 8'b0010_0000,
        ST_DIV_R = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    pwsel_pkg::t_row      r_row;
    logic [NW+QW-1:0]     r_nq;
    logic [2*SW-1:0]      r_ss;
    logic [2*NW-1:0]      r_nn;
    logic signed [EW+16:0] r_prod;
    logic signed [63:0]   r_bsum, r_wsum;
    logic [31:0]          r_cnt;
    logic signed [47:0]   r_res;
    logic                 r_total, r_neg;
    logic                 r_ov;
    pwsel_pkg::t_out_item r_out;

    pwsel_pkg::t_div_req  div_req;
    logic                 div_done;
    logic [DW-1:0]        div_q;

    logic [SW-1:0]        sum_mag;
    logic [NW+QW:0]       num;
    logic signed [63:0]   rl, new_b, new_w, den;
    logic [31:0]          new_c;
    logic [63:0]          b_mag, d_mag;
    logic                 load_out;

    function automatic logic signed [63:0] sat_acc(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (s > pwsel_pkg::ACC_LIM) s = pwsel_pkg::ACC_LIM;
        if (s < -pwsel_pkg::ACC_LIM) s = -pwsel_pkg::ACC_LIM;
        return s;
    endfunction

    pwsel_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign sum_mag = r_row.diff_sum[SW-1] ? SW'(-r_row.diff_sum) : r_row.diff_sum;
    assign num     = (r_nq > (NW+QW)'(r_ss)) ? (NW+QW+1)'(r_nq - (NW+QW)'(r_ss)) : '0;

    // floor(E * w / 256)
    assign rl    = $signed({{(64-EW-17){r_prod[EW+16]}}, r_prod}) >>> 8;
    assign new_b = sat_acc(r_bsum, rl);
    assign new_w = sat_acc(r_wsum, 64'(r_row.weight));
    assign new_c = ((r_row.weight != '0) && (r_cnt != '1)) ? r_cnt + 1'b1 : r_cnt;
    assign den   = (i_mode == pwsel_pkg::MODE_MEAN) ? new_w : $signed({32'd0, new_c});
    assign b_mag = new_b[63] ? 64'(-new_b) : 64'(new_b);
    assign d_mag = den[63] ? 64'(-den) : 64'(den);

    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign load_out = (r_state == ST_EMIT) && (!r_ov || i_ready);
    assign o_valid  = r_ov;
    assign o_item   = r_out;

    always_comb begin
        div_req = '{start: 1'b0, dividend: '0, divisor: '0};
        if (r_state == ST_DIFF) begin
            div_req = '{start: 1'b1, dividend: DW'({num, 2'b00}), divisor: BW'(r_nn)};
        end else if (r_state == ST_ACC && r_row.batch_end &&
                     (i_mode == pwsel_pkg::MODE_MEAN || i_mode == pwsel_pkg::MODE_NZ) &&
                     den != '0) begin
            div_req.start    = 1'b1;
            div_req.divisor  = d_mag;
            div_req.dividend = (i_mode == pwsel_pkg::MODE_MEAN) ? DW'({b_mag, 8'd0})
                                                                : DW'(b_mag);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_q_valid) n_state = ST_MUL;
            ST_MUL:   n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_DIV_E;
            ST_DIV_E: if (div_done) n_state = ST_WMUL;
            ST_WMUL:  n_state = ST_ACC;
            ST_ACC: begin
                if (i_mode == pwsel_pkg::MODE_ROW) n_state = ST_EMIT;
                else if (!r_row.batch_end) n_state = ST_IDLE;
                else if (div_req.start) n_state = ST_DIV_R;
                else n_state = ST_EMIT;
            end
            ST_DIV_R: if (div_done) n_state = ST_EMIT;
            ST_EMIT:  if (load_out) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_row <= i_row;
        if (r_state == ST_MUL) begin
            r_nq <= r_row.n * r_row.sq_sum;
            r_ss <= sum_mag * sum_mag;
            r_nn <= r_row.n * (r_row.n - 1'b1);
        end
        if (r_state == ST_DIV_E && div_done) begin
            r_prod <= $signed({1'b0, div_q[EW-1:0]}) * r_row.weight;
        end
        if (r_state == ST_ACC) begin
            r_total <= (i_mode != pwsel_pkg::MODE_ROW);
            r_neg   <= new_b[63] ^ den[63];
            if (i_mode == pwsel_pkg::MODE_ROW) r_res <= pwsel_pkg::sat48(rl);
            else if (i_mode == pwsel_pkg::MODE_SUM) r_res <= pwsel_pkg::sat48(new_b);
            else r_res <= '0;   // zero divisor
        end
        if (r_state == ST_DIV_R && div_done) begin
            if (div_q > DW'(pwsel_pkg::OUT_MAX)) begin
                r_res <= r_neg ? pwsel_pkg::OUT_MIN[47:0] : pwsel_pkg::OUT_MAX[47:0];
            end else begin
                r_res <= r_neg ? 48'(-div_q[47:0]) : div_q[47:0];
            end
        end
        if (load_out) r_out <= '{loss: r_res, is_total: r_total};

        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_bsum  <= '0;
            r_wsum  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (load_out) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            if (r_state == ST_ACC) begin
                if (r_row.batch_end) begin
                    r_bsum <= '0;
                    r_wsum <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_bsum <= new_b;
                    r_wsum <= new_w;
                    r_cnt  <= new_c;
                end
            end
        end
    end

    a_bsum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bsum <= pwsel_pkg::ACC_LIM) && (r_bsum >= -pwsel_pkg::ACC_LIM))
        else $error("batch sum left saturation range");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV_E || r_state == ST_DIV_R))
        else $error("divider finished outside a wait state");
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == ST_EMIT))
        else $error("result shown without emit step");
endmodule

FILE: rtl/pairwise_sq_error_loss.sv
// Streaming weighted pairwise squared error loss. One prediction/label pair is
// taken per cycle while the row queue has room; the front accumulates each row
// and queues finished rows (two deep) for the back, which takes one row at a
// time, computes its loss with the 72-step shared divider and divides once
// more at batch end in the mean modes. When the back falls behind, as on short
// rows, the queue fills and stalls the input. Results pass through an output
// register. Registers: 0 mode, 1 feature count, at byte addresses 0 and 4.
module pairwise_sq_error_loss #(
    parameter int FEATURES_MAX = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  pwsel_pkg::t_in_item  i_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pwsel_pkg::t_out_item o_out
);
    logic [1:0]      r_mode;
    logic [8:0]      r_fc;
    logic            q_full, q_push, q_pop, q_valid;
    pwsel_pkg::t_row f_row, q_row;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pwsel_pkg::ADDR_FC) ? {23'd0, r_fc} : {30'd0, r_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pwsel_pkg::MODE_SUM;
            r_fc   <= 9'd2;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == pwsel_pkg::ADDR_MODE) r_mode <= pwdata[1:0];
            else r_fc <= pwdata[8:0];
        end
    end

    pwsel_front #(.FEATURES_MAX(FEATURES_MAX)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_feature_count (r_fc),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_item          (i_in),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_row           (f_row)
    );

    pwsel_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_row),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_row)
    );

    pwsel_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_mode),
        .i_q_valid (q_valid),
        .i_row     (q_row),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_out)
    );
endmodule

FILE: sim/tb_pairwise_sq_error_loss.sv
`timescale 1ns / 1ps

module tb_pairwise_sq_error_loss;

    localparam int CLK_HALF   = 5;
    localparam int SETTLE     = 600;   // back end: 2 rows queued plus the batch-end division
    localparam int STALL_LIM  = 6000;
    localparam int HOLD_LEN   = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid, o_ready, o_valid, i_ready;
    pwsel_pkg::t_in_item  i_in;
    pwsel_pkg::t_out_item o_out;

    pairwise_sq_error_loss dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready), .i_in(i_in),
        .o_valid(o_valid), .i_ready(i_ready), .o_out(o_out)
    );

    // predictor state
    logic [1:0]      mode_cfg;
    logic [8:0]      fcount_cfg;
    longint          row_dsum;
    longint unsigned row_sqsum;
    int unsigned     row_idx;
    longint          batch_sum;
    longint          batch_wsum;
    int unsigned     nz_count;

    pwsel_pkg::t_in_item  feed_q[$];
    pwsel_pkg::t_out_item loss_q[$];
    int        errors, n_items, n_results, n_totals, n_rows;
    int        stall_cnt;
    bit        no_gaps;
    int        hold_req, hold_seen, hold_left;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic longint clamp48(longint v);
        if (v > pwsel_pkg::OUT_MAX) return pwsel_pkg::OUT_MAX;
        if (v < pwsel_pkg::OUT_MIN) return pwsel_pkg::OUT_MIN;
        return v;
    endfunction

    function automatic longint acc_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > pwsel_pkg::ACC_LIM) return pwsel_pkg::ACC_LIM;
        if (s < -pwsel_pkg::ACC_LIM) return -pwsel_pkg::ACC_LIM;
        return s;
    endfunction

    // num * 2^fb / den, truncated toward zero, saturated
    function automatic longint quot_sat(longint num, longint den, int fb);
        longint unsigned a, b, q, r;
        bit neg;
        if (den == 0) return 0;
        neg = (num < 0) != (den < 0);
        a = (num < 0) ? -num : num;
        b = (den < 0) ? -den : den;
        q = a / b;
        r = a % b;
        if (q >= (64'd1 << 47)) return neg ? pwsel_pkg::OUT_MIN : pwsel_pkg::OUT_MAX;
        for (int i = 0; i < fb; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b) begin
                r = r - b;
                q = q | 64'd1;
            end
        end
        if (q > pwsel_pkg::OUT_MAX) return neg ? pwsel_pkg::OUT_MIN : pwsel_pkg::OUT_MAX;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic void clear_batch();
        batch_sum  = 0;
        batch_wsum = 0;
        nz_count   = 0;
    endfunction

    function automatic void predict_loss(pwsel_pkg::t_in_item it);
        longint unsigned n, mag, nq, ss, num, e;
        longint d, w, row_loss, v;
        pwsel_pkg::t_out_item r;
        n = fcount_cfg;
        if (n < 2) n = 2;
        if (n > 256) n = 256;
        d = longint'(it.prediction) - longint'(it.label);
        row_dsum += d;
        mag = (d < 0) ? -d : d;
        row_sqsum += mag * mag;
        row_idx++;
        if (row_idx < n) return;
        n_rows++;
        mag = (row_dsum < 0) ? -row_dsum : row_dsum;
        nq = n * row_sqsum;
        ss = mag * mag;
        num = (nq > ss) ? nq - ss : 0;
        e = (num * 4) / (n * (n - 1));
        w = longint'(it.row_weight);
        row_loss = (longint'(e) * w) >>> 8;   // floor division by 256
        row_dsum = 0;
        row_sqsum = 0;
        row_idx = 0;
        batch_sum = acc_add(batch_sum, row_loss);
        batch_wsum = acc_add(batch_wsum, w);
        if (w != 0 && nz_count != 32'hFFFF_FFFF) nz_count++;
        if (mode_cfg == pwsel_pkg::MODE_ROW) begin
            v = clamp48(row_loss);
            r.loss = v[47:0];
            r.is_total = 1'b0;
            loss_q.push_back(r);
            if (it.batch_end) clear_batch();
            return;
        end
        if (!it.batch_end) return;
        case (mode_cfg)
            pwsel_pkg::MODE_SUM:  v = clamp48(batch_sum);
            pwsel_pkg::MODE_MEAN: v = quot_sat(batch_sum, batch_wsum, 8);
            default:              v = quot_sat(batch_sum, longint'(nz_count), 0);
        endcase
        r.loss = v[47:0];
        r.is_total = 1'b1;
        loss_q.push_back(r);
        clear_batch();
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                predict_loss(i_in);
                n_items++;
            end
            if (feed_q.size() > 0 && (no_gaps || $urandom_range(99) >= 27)) begin
                i_valid <= 1'b1;
                i_in <= feed_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver; a hold request makes it back off for a long stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            i_ready <= 1'b0;
        end else begin
            i_ready <= no_gaps || ($urandom_range(99) >= 27);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        pwsel_pkg::t_out_item x;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (o_out.is_total) n_totals++;
            if (loss_q.size() == 0) begin
                $error("unexpected result loss=%0d is_total=%0b", o_out.loss, o_out.is_total);
                errors++;
            end else begin
                x = loss_q.pop_front();
                if (o_out.loss !== x.loss) begin
                    $error("loss: expected %0d, got %0d", x.loss, o_out.loss);
                    errors++;
                end
                if (o_out.is_total !== x.is_total) begin
                    $error("is_total: expected %0b, got %0b", x.is_total, o_out.is_total);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || psel)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIM) begin
            $display("timeout: nothing moved for %0d cycles", STALL_LIM);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic reg_write(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == pwsel_pkg::ADDR_MODE) mode_cfg = val[1:0];
        else fcount_cfg = val[8:0];
    endtask

    task automatic set_cfg(input logic [1:0] m, input logic [8:0] fc);
        reg_write(pwsel_pkg::ADDR_MODE, 32'(m));
        reg_write(pwsel_pkg::ADDR_FC, 32'(fc));
    endtask

    task automatic drain();
        while (feed_q.size() > 0 || i_valid || loss_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic add_item(input int p, input int l, input int w, input bit be);
        pwsel_pkg::t_in_item it;
        it.prediction = 16'(p);
        it.label = 16'(l);
        it.row_weight = 16'(w);
        it.batch_end = be;
        feed_q.push_back(it);
    endtask

    function automatic int rnd_elem();
        case ($urandom_range(3))
            0: return $urandom_range(200) - 100;
            1: return $urandom_range(1) ? 32767 : -32768;
            default: return int'(16'($urandom));
        endcase
    endfunction

    function automatic int rnd_weight();
        case ($urandom_range(5))
            0: return 0;
            1: return $urandom_range(1) ? 32767 : -32768;
            2: return $urandom_range(512) - 256;
            default: return int'(16'($urandom));
        endcase
    endfunction

    // one row of n random elements; weight and batch flag matter on the last
    task automatic add_row(input int n, input int w, input bit be);
        for (int i = 0; i < n - 1; i++)
            add_item(rnd_elem(), rnd_elem(), int'(16'($urandom)), $urandom_range(1));
        add_item(rnd_elem(), rnd_elem(), w, be);
    endtask

    initial begin
        int n_eff, rows;
        logic [1:0] m;
        logic [8:0] fc;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0; i_ready = 1'b0; i_in = '0;
        i_rst_n = 1'b0;
        errors = 0; n_items = 0; n_results = 0; n_totals = 0; n_rows = 0;
        stall_cnt = 0; no_gaps = 1'b0; hold_req = 0; hold_seen = 0; hold_left = 0;
        mode_cfg = pwsel_pkg::MODE_SUM; fcount_cfg = 9'd2;
        row_dsum = 0; row_sqsum = 0; row_idx = 0;
        clear_batch();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes per row
        set_cfg(pwsel_pkg::MODE_ROW, 9'd2);
        add_item(32767, -32768, 32767, 0);
        add_item(-32768, 32767, 32767, 0);
        add_item(-32768, 32767, -32768, 0);
        add_item(32767, -32768, -32768, 0);
        add_item(0, 0, 0, 0);
        add_item(32767, 32767, 1, 1);
        add_item(5, 3, 256, 0);
        add_item(-5, 3, -256, 1);
        drain();
        // weighted mean saturates: weight total of one, huge sum
        set_cfg(pwsel_pkg::MODE_MEAN, 9'd2);
        add_item(32767, -32768, 32767, 0);
        add_item(-32768, 32767, 32767, 0);
        add_item(7, 7, -32766, 0);
        add_item(7, 7, -32766, 1);
        // weights cancel: zero divisor
        add_item(100, -100, 5, 0);
        add_item(-100, 100, 5, 0);
        add_item(300, 0, -5, 0);
        add_item(0, 300, -5, 1);
        drain();
        // no nonzero weight: zero divisor
        set_cfg(pwsel_pkg::MODE_NZ, 9'd0);
        add_item(1000, -1000, 0, 0);
        add_item(-1000, 1000, 0, 1);
        drain();
        // count lowered mid-row: row closes on next element
        set_cfg(pwsel_pkg::MODE_ROW, 9'd8);
        for (int i = 0; i < 5; i++) add_item(rnd_elem(), rnd_elem(), 0, 0);
        drain();
        reg_write(pwsel_pkg::ADDR_FC, 32'd3);
        add_item(1234, -4321, 32767, 1);
        drain();

        // output saturation in sum mode, gap-free
        set_cfg(pwsel_pkg::MODE_SUM, 9'd2);
        no_gaps = 1'b1;
        for (int i = 0; i < 40; i++) begin
            add_item(32767, -32768, 32767, 0);
            add_item(-32768, 32767, 32767, i == 39);
        end
        drain();
        no_gaps = 1'b0;

        // long receiver hold-off while short rows keep coming
        set_cfg(pwsel_pkg::MODE_ROW, 9'd2);
        hold_req++;
        for (int i = 0; i < 60; i++) add_row(2, rnd_weight(), $urandom_range(3) == 0);
        drain();

        // largest rows, only a few
        set_cfg(pwsel_pkg::MODE_MEAN, 9'd511);
        add_row(256, rnd_weight(), 0);
        add_row(256, rnd_weight(), 1);
        drain();

        // random phases, mostly short rows
        for (int ph = 0; ph < 14; ph++) begin
            m = 2'($urandom_range(3));
            case ($urandom_range(5))
                0: fc = 9'($urandom_range(1));
                1: fc = 9'd2;
                2: fc = 9'($urandom_range(60, 20));
                default: fc = 9'($urandom_range(12, 3));
            endcase
            set_cfg(m, fc);
            n_eff = (fc < 2) ? 2 : fc;
            rows = 60 / n_eff + 1;
            no_gaps = (ph == 5);
            for (int r = 0; r < rows; r++)
                add_row(n_eff, rnd_weight(), (r == rows - 1) || ($urandom_range(3) == 0));
            drain();
        end
        no_gaps = 1'b0;
        set_cfg(pwsel_pkg::MODE_SUM, 9'd2);

        drain();
        $display("covered %0d items, %0d rows, %0d results (%0d batch totals)",
                 n_items, n_rows, n_results, n_totals);
        $display("all four reduction modes, feature counts 0..511, zero divisors, saturation");
        if (errors == 0 && loss_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, loss_q.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/pwsel_pkg.sv
rtl/pwsel_queue.sv
rtl/pwsel_front.sv
rtl/pwsel_div.sv
rtl/pwsel_back.sv
rtl/pairwise_sq_error_loss.sv
sim/tb_pairwise_sq_error_loss.sv
